[rtl/tpmc_pkg.sv]
`timescale 1ns / 1ps

package tpmc_pkg;

    // Widths fixed by the converter word and the calibration registers
    localparam int WORD_W    = 16;
    localparam int CFG_W     = 12;
    localparam int QUOT_W    = 12;
    localparam int NUM_W     = 2 * CFG_W;
    localparam int CFG_IDX_W = 3;

    // Defaults handed to the top level parameters
    localparam int SAMPLE_BITS_DEF = 12;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_X_RAW_MIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_X_RAW_MAX = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Y_RAW_MIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_RAW_MAX = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_X_OUT_MAX = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_Y_OUT_MAX = 3'd5;

    // Register reset values
    localparam logic [CFG_W-1:0] RST_X_RAW_MIN = 12'd150;
    localparam logic [CFG_W-1:0] RST_X_RAW_MAX = 12'd3550;
    localparam logic [CFG_W-1:0] RST_Y_RAW_MIN = 12'd150;
    localparam logic [CFG_W-1:0] RST_Y_RAW_MAX = 12'd3500;
    localparam logic [CFG_W-1:0] RST_X_OUT_MAX = 12'd319;
    localparam logic [CFG_W-1:0] RST_Y_OUT_MAX = 12'd239;

    // Calibration of one screen axis
    typedef struct packed {
        logic [CFG_W-1:0] lo;
        logic [CFG_W-1:0] hi;
        logic [CFG_W-1:0] top;
    } t_axis_cfg;

    // One axis after clamping, before the multiply
    typedef struct packed {
        logic [CFG_W-1:0] diff;
        logic [CFG_W-1:0] den;
        logic [CFG_W-1:0] top;
    } t_axis_pre;

    // One axis ready for the divider
    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [CFG_W-1:0] den;
        logic [CFG_W-1:0] top;
    } t_axis_job;

    // Queue entry: one touch event after the front end
    typedef struct packed {
        logic      pen;
        t_axis_job ax;
        t_axis_job ay;
    } t_job;

endpackage

[rtl/touch_point_median_calibrate_core.sv]
`timescale 1ns / 1ps

// Touch point conditioning: median of three samples per channel, axis swap,
// window clamp, linear scaling and mirroring to screen coordinates.
//
// Input channel: one transaction per touch event (pen flag and three raw
// converter words per channel), taken on i_in_valid high with o_in_stall low.
// Output channel: one transaction per input transaction, in order, taken on
// o_out_valid high with i_out_stall low.
// Throughput: one transaction per cycle while the output is not stalled. Each
// axis runs through a 12-stage restoring divider, one quotient bit per stage,
// so every stage is free for a new event each cycle.
// Path: the result passes two front stages, one queue slot, twelve divider
// stages and the output register.
// Stalls: a stalled output holds its transaction and freezes the back end;
// the front end keeps taking transactions until the queue fills, then raises
// o_in_stall.
// Reset: synchronous, active low; empties the pipeline and queue and loads
// the calibration registers with their defaults. Write registers only while
// the block is idle.
module touch_point_median_calibrate_core #(
    parameter int SAMPLE_BITS = tpmc_pkg::SAMPLE_BITS_DEF,
    parameter int QUEUE_DEPTH = tpmc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [tpmc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tpmc_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_pen_down,
    input  logic [tpmc_pkg::WORD_W-1:0]    i_xchan_word_a,
    input  logic [tpmc_pkg::WORD_W-1:0]    i_xchan_word_b,
    input  logic [tpmc_pkg::WORD_W-1:0]    i_xchan_word_c,
    input  logic [tpmc_pkg::WORD_W-1:0]    i_ychan_word_a,
    input  logic [tpmc_pkg::WORD_W-1:0]    i_ychan_word_b,
    input  logic [tpmc_pkg::WORD_W-1:0]    i_ychan_word_c,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_point_valid,
    output logic [tpmc_pkg::CFG_W-1:0]     o_screen_x,
    output logic [tpmc_pkg::CFG_W-1:0]     o_screen_y
);

    // Calibration registers
    logic [tpmc_pkg::CFG_W-1:0] r_x_raw_min;
    logic [tpmc_pkg::CFG_W-1:0] r_x_raw_max;
    logic [tpmc_pkg::CFG_W-1:0] r_y_raw_min;
    logic [tpmc_pkg::CFG_W-1:0] r_y_raw_max;
    logic [tpmc_pkg::CFG_W-1:0] r_x_out_max;
    logic [tpmc_pkg::CFG_W-1:0] r_y_out_max;

    tpmc_pkg::t_axis_cfg w_cfg_x;
    tpmc_pkg::t_axis_cfg w_cfg_y;
    logic                w_push;
    logic                w_pop;
    logic                w_q_full;
    logic                w_q_empty;
    tpmc_pkg::t_job      w_job_in;
    tpmc_pkg::t_job      w_job_out;

    // Decode register writes; ignore indexes beyond the list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_raw_min <= tpmc_pkg::RST_X_RAW_MIN;
            r_x_raw_max <= tpmc_pkg::RST_X_RAW_MAX;
            r_y_raw_min <= tpmc_pkg::RST_Y_RAW_MIN;
            r_y_raw_max <= tpmc_pkg::RST_Y_RAW_MAX;
            r_x_out_max <= tpmc_pkg::RST_X_OUT_MAX;
            r_y_out_max <= tpmc_pkg::RST_Y_OUT_MAX;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tpmc_pkg::REG_X_RAW_MIN: r_x_raw_min <= i_cfg_wdata;
                tpmc_pkg::REG_X_RAW_MAX: r_x_raw_max <= i_cfg_wdata;
                tpmc_pkg::REG_Y_RAW_MIN: r_y_raw_min <= i_cfg_wdata;
                tpmc_pkg::REG_Y_RAW_MAX: r_y_raw_max <= i_cfg_wdata;
                tpmc_pkg::REG_X_OUT_MAX: r_x_out_max <= i_cfg_wdata;
                tpmc_pkg::REG_Y_OUT_MAX: r_y_out_max <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign w_cfg_x = '{lo: r_x_raw_min, hi: r_x_raw_max, top: r_x_out_max};
    assign w_cfg_y = '{lo: r_y_raw_min, hi: r_y_raw_max, top: r_y_out_max};

    // Front end: sample, median, clamp, multiply
    tpmc_front #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in_valid),
        .o_stall       (o_in_stall),
        .i_pen_down    (i_pen_down),
        .i_xchan_word_a(i_xchan_word_a),
        .i_xchan_word_b(i_xchan_word_b),
        .i_xchan_word_c(i_xchan_word_c),
        .i_ychan_word_a(i_ychan_word_a),
        .i_ychan_word_b(i_ychan_word_b),
        .i_ychan_word_c(i_ychan_word_c),
        .i_cfg_x       (w_cfg_x),
        .i_cfg_y       (w_cfg_y),
        .o_push        (w_push),
        .o_job         (w_job_in),
        .i_full        (w_q_full)
    );

    // Queue between the two halves
    tpmc_fifo #(
        .DEPTH(QUEUE_DEPTH)
    ) u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_job  (w_job_in),
        .o_full (w_q_full),
        .i_pop  (w_pop),
        .o_job  (w_job_out),
        .o_empty(w_q_empty)
    );

    // Back end: pipelined divide, mirror, output register
    tpmc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (w_q_empty),
        .o_pop        (w_pop),
        .i_job        (w_job_out),
        .o_valid      (o_out_valid),
        .i_stall      (i_out_stall),
        .o_point_valid(o_point_valid),
        .o_screen_x   (o_screen_x),
        .o_screen_y   (o_screen_y)
    );

    // Pen up must give zero coordinates
    a_pen_up_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_point_valid |-> o_screen_x == '0 && o_screen_y == '0)
        else $error("pen-up result carries non-zero coordinates");

    // Divider quotient never exceeds the screen range
    a_x_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_point_valid |-> o_screen_x <= r_x_out_max)
        else $error("screen x beyond its range");

    a_y_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_point_valid |-> o_screen_y <= r_y_out_max)
        else $error("screen y beyond its range");

    // Front end stalls only on a full queue
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> w_q_full)
        else $error("input stalled without a full queue");

endmodule

[rtl/tpmc_front.sv]
`timescale 1ns / 1ps

module tpmc_front #(
    parameter int SAMPLE_BITS = tpmc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_pen_down,
    input  logic [tpmc_pkg::WORD_W-1:0] i_xchan_word_a,
    input  logic [tpmc_pkg::WORD_W-1:0] i_xchan_word_b,
    input  logic [tpmc_pkg::WORD_W-1:0] i_xchan_word_c,
    input  logic [tpmc_pkg::WORD_W-1:0] i_ychan_word_a,
    input  logic [tpmc_pkg::WORD_W-1:0] i_ychan_word_b,
    input  logic [tpmc_pkg::WORD_W-1:0] i_ychan_word_c,
    input  tpmc_pkg::t_axis_cfg         i_cfg_x,
    input  tpmc_pkg::t_axis_cfg         i_cfg_y,
    output logic                        o_push,
    output tpmc_pkg::t_job              o_job,
    input  logic                        i_full
);

    localparam int CW = (SAMPLE_BITS > tpmc_pkg::CFG_W) ? SAMPLE_BITS : tpmc_pkg::CFG_W;

    function automatic logic [SAMPLE_BITS-1:0] take_sample(
        input logic [tpmc_pkg::WORD_W-1:0] w
    );
        return w[tpmc_pkg::WORD_W-1 -: SAMPLE_BITS];
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] median3(
        input logic [SAMPLE_BITS-1:0] a,
        input logic [SAMPLE_BITS-1:0] b,
        input logic [SAMPLE_BITS-1:0] c
    );
        logic [SAMPLE_BITS-1:0] lo_ab;
        logic [SAMPLE_BITS-1:0] hi_ab;
        logic [SAMPLE_BITS-1:0] m;
        lo_ab = (a < b) ? a : b;
        hi_ab = (a < b) ? b : a;
        m     = (hi_ab < c) ? hi_ab : c;
        return (lo_ab > m) ? lo_ab : m;
    endfunction

    // Clamp to the window; an empty window gives a zero numerator over one
    function automatic tpmc_pkg::t_axis_pre prep(
        input logic [SAMPLE_BITS-1:0] v,
        input tpmc_pkg::t_axis_cfg    c
    );
        logic [CW-1:0]       vc;
        tpmc_pkg::t_axis_pre p;
        vc = CW'(v);
        if (vc < CW'(c.lo)) vc = CW'(c.lo);
        if (vc > CW'(c.hi)) vc = CW'(c.hi);
        p.top = c.top;
        if (c.hi > c.lo) begin
            p.diff = vc[tpmc_pkg::CFG_W-1:0] - c.lo;
            p.den  = c.hi - c.lo;
        end else begin
            p.diff = '0;
            p.den  = tpmc_pkg::CFG_W'(1);
        end
        return p;
    endfunction

    logic                    w_adv;
    logic [SAMPLE_BITS-1:0]  w_xmed;
    logic [SAMPLE_BITS-1:0]  w_ymed;

    logic                    r_s1_valid;
    logic                    r_s1_pen;
    tpmc_pkg::t_axis_pre     r_s1_x;
    logic                    r_s1_y_unused_guard;
    tpmc_pkg::t_axis_pre     r_s1_y;
    logic                    r_s2_valid;
    tpmc_pkg::t_job          r_s2_job;

    assign w_adv   = !r_s2_valid || !i_full;
    assign o_stall = !w_adv;
    assign o_push  = r_s2_valid && !i_full;
    assign o_job   = r_s2_job;

    assign w_xmed = median3(take_sample(i_xchan_word_a), take_sample(i_xchan_word_b),
                            take_sample(i_xchan_word_c));
    assign w_ymed = median3(take_sample(i_ychan_word_a), take_sample(i_ychan_word_b),
                            take_sample(i_ychan_word_c));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
        end
    end

    // Landscape: Y channel drives screen X
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_pen            <= i_pen_down;
            r_s1_x              <= prep(w_ymed, i_cfg_x);
            r_s1_y              <= prep(w_xmed, i_cfg_y);
            r_s1_y_unused_guard <= i_valid;
            r_s2_job.pen        <= r_s1_pen && r_s1_y_unused_guard;
            r_s2_job.ax.num     <= tpmc_pkg::NUM_W'(r_s1_x.diff) * tpmc_pkg::NUM_W'(r_s1_x.top);
            r_s2_job.ax.den     <= r_s1_x.den;
            r_s2_job.ax.top     <= r_s1_x.top;
            r_s2_job.ay.num     <= tpmc_pkg::NUM_W'(r_s1_y.diff) * tpmc_pkg::NUM_W'(r_s1_y.top);
            r_s2_job.ay.den     <= r_s1_y.den;
            r_s2_job.ay.top     <= r_s1_y.top;
        end
    end

endmodule

[rtl/tpmc_fifo.sv]
`timescale 1ns / 1ps

module tpmc_fifo #(
    parameter int DEPTH = tpmc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tpmc_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output tpmc_pkg::t_job o_job,
    output logic           o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tpmc_pkg::t_job   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

[rtl/tpmc_back.sv]
`timescale 1ns / 1ps

module tpmc_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_empty,
    output logic                       o_pop,
    input  tpmc_pkg::t_job             i_job,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic                       o_point_valid,
    output logic [tpmc_pkg::CFG_W-1:0] o_screen_x,
    output logic [tpmc_pkg::CFG_W-1:0] o_screen_y
);

    localparam int STEPS = tpmc_pkg::QUOT_W;
    localparam int W     = tpmc_pkg::CFG_W;

    typedef struct packed {
        logic [W-1:0] rem;
        logic [W-1:0] low;
        logic [W-1:0] q;
        logic [W-1:0] den;
        logic [W-1:0] top;
    } t_axis_div;

    // Numerator is below den * 2^W, so the upper half already sits below den
    function automatic t_axis_div div_init(input tpmc_pkg::t_axis_job j);
        t_axis_div d;
        d.rem = j.num[tpmc_pkg::NUM_W-1:W];
        d.low = j.num[W-1:0];
        d.q   = '0;
        d.den = j.den;
        d.top = j.top;
        return d;
    endfunction

    // One restoring step: one quotient bit
    function automatic t_axis_div div_step(input t_axis_div d);
        t_axis_div n;
        logic [W:0] t;
        n = d;
        t = {d.rem, d.low[W-1]};
        n.low = {d.low[W-2:0], 1'b0};
        if (t >= {1'b0, d.den}) begin
            t     = t - {1'b0, d.den};
            n.q   = {d.q[W-2:0], 1'b1};
        end else begin
            n.q   = {d.q[W-2:0], 1'b0};
        end
        n.rem = t[W-1:0];
        return n;
    endfunction

    logic      w_adv;
    t_axis_div w_in_x [1:STEPS];
    t_axis_div w_in_y [1:STEPS];
    logic      w_in_p [1:STEPS];

    logic      r_v   [1:STEPS];
    logic      r_pen [1:STEPS];
    t_axis_div r_dx  [1:STEPS];
    t_axis_div r_dy  [1:STEPS];

    logic         r_out_valid;
    logic         r_out_pen;
    logic [W-1:0] r_out_x;
    logic [W-1:0] r_out_y;

    assign w_adv = !(r_out_valid && i_stall);
    assign o_pop = w_adv && !i_empty;

    always_comb begin
        w_in_x[1] = div_init(i_job.ax);
        w_in_y[1] = div_init(i_job.ay);
        w_in_p[1] = i_job.pen;
        for (int k = 2; k <= STEPS; k++) begin
            w_in_x[k] = r_dx[k-1];
            w_in_y[k] = r_dy[k-1];
            w_in_p[k] = r_pen[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= STEPS; k++) begin
                r_v[k] <= 1'b0;
            end
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_v[1] <= o_pop;
            for (int k = 2; k <= STEPS; k++) begin
                r_v[k] <= r_v[k-1];
            end
            r_out_valid <= r_v[STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 1; k <= STEPS; k++) begin
                r_dx[k]  <= div_step(w_in_x[k]);
                r_dy[k]  <= div_step(w_in_y[k]);
                r_pen[k] <= w_in_p[k];
            end
            // Mirror; pen up gives zeros
            r_out_pen <= r_pen[STEPS];
            r_out_x   <= r_pen[STEPS] ? (r_dx[STEPS].top - r_dx[STEPS].q) : '0;
            r_out_y   <= r_pen[STEPS] ? (r_dy[STEPS].top - r_dy[STEPS].q) : '0;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_point_valid = r_out_pen;
    assign o_screen_x    = r_out_x;
    assign o_screen_y    = r_out_y;

endmodule

[dv/touch_point_checker.sv]
`timescale 1ns / 1ps

module touch_point_checker #(
    parameter int SAMPLE_BITS = tpmc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [tpmc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tpmc_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic                           i_pen_down,
    input  logic [tpmc_pkg::WORD_W-1:0]    i_xchan_word_a,
    input  logic [tpmc_pkg::WORD_W-1:0]    i_xchan_word_b,
    input  logic [tpmc_pkg::WORD_W-1:0]    i_xchan_word_c,
    input  logic [tpmc_pkg::WORD_W-1:0]    i_ychan_word_a,
    input  logic [tpmc_pkg::WORD_W-1:0]    i_ychan_word_b,
    input  logic [tpmc_pkg::WORD_W-1:0]    i_ychan_word_c,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic                           i_point_valid,
    input  logic [tpmc_pkg::CFG_W-1:0]     i_screen_x,
    input  logic [tpmc_pkg::CFG_W-1:0]     i_screen_y,
    output int                             o_mismatches,
    output int                             o_pending,
    output int                             o_points_checked
);
    import tpmc_pkg::*;

    typedef struct packed {
        logic             pen;
        logic [CFG_W-1:0] sx;
        logic [CFG_W-1:0] sy;
    } touch_point_t;

    touch_point_t     expected_points[$];
    logic [CFG_W-1:0] cal_x_lo, cal_x_hi, cal_y_lo, cal_y_hi, cal_x_top, cal_y_top;
    int               mismatch_count = 0;
    int               checked_count = 0;

    function automatic logic [CFG_W-1:0] converter_sample(input logic [WORD_W-1:0] word);
        logic [WORD_W-1:0] shifted;
        shifted = word >> (WORD_W - SAMPLE_BITS);
        return shifted[CFG_W-1:0];
    endfunction

    function automatic logic [CFG_W-1:0] median3(input logic [CFG_W-1:0] a, b, c);
        logic [CFG_W-1:0] t;
        if (a > b) begin t = a; a = b; b = t; end
        if (b > c) begin t = b; b = c; c = t; end
        if (a > b) begin t = a; a = b; b = t; end
        return b;
    endfunction

    // Clamp into the window, scale, then mirror; an empty window scales to 0
    function automatic logic [CFG_W-1:0] calibrate_axis(input logic [CFG_W-1:0] raw, lo, hi,
                                                        input logic [CFG_W-1:0] top);
        int unsigned v, scaled, mirrored;
        scaled = 0;
        if (hi > lo) begin
            v = raw;
            if (v < lo) v = lo;
            if (v > hi) v = hi;
            scaled = ((v - lo) * top) / (hi - lo);
        end
        mirrored = top - scaled;
        return mirrored[CFG_W-1:0];
    endfunction

    // Landscape: Y channel drives screen x, X channel drives screen y
    function automatic touch_point_t predict_point();
        touch_point_t p;
        logic [CFG_W-1:0] x_med, y_med;
        p = '0;
        if (i_pen_down) begin
            x_med = median3(converter_sample(i_xchan_word_a), converter_sample(i_xchan_word_b),
                            converter_sample(i_xchan_word_c));
            y_med = median3(converter_sample(i_ychan_word_a), converter_sample(i_ychan_word_b),
                            converter_sample(i_ychan_word_c));
            p.pen = 1'b1;
            p.sx  = calibrate_axis(y_med, cal_x_lo, cal_x_hi, cal_x_top);
            p.sy  = calibrate_axis(x_med, cal_y_lo, cal_y_hi, cal_y_top);
        end
        return p;
    endfunction

    task automatic check_field(input string field, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        touch_point_t want;
        if (!i_rst_n) begin
            cal_x_lo  = RST_X_RAW_MIN;
            cal_x_hi  = RST_X_RAW_MAX;
            cal_y_lo  = RST_Y_RAW_MIN;
            cal_y_hi  = RST_Y_RAW_MAX;
            cal_x_top = RST_X_OUT_MAX;
            cal_y_top = RST_Y_OUT_MAX;
            expected_points.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_X_RAW_MIN: cal_x_lo  = i_cfg_wdata;
                    REG_X_RAW_MAX: cal_x_hi  = i_cfg_wdata;
                    REG_Y_RAW_MIN: cal_y_lo  = i_cfg_wdata;
                    REG_Y_RAW_MAX: cal_y_hi  = i_cfg_wdata;
                    REG_X_OUT_MAX: cal_x_top = i_cfg_wdata;
                    REG_Y_OUT_MAX: cal_y_top = i_cfg_wdata;
                    default: ;  // drop writes past the register list
                endcase
            end
            if (i_in_valid && !i_in_stall)
                expected_points.push_back(predict_point());
            if (i_out_valid && !i_out_stall) begin
                checked_count++;
                if (expected_points.size() == 0) begin
                    $display("%0t: unexpected point: expected none, got valid %0d x %0d y %0d",
                             $time, i_point_valid, i_screen_x, i_screen_y);
                    mismatch_count++;
                end else begin
                    want = expected_points.pop_front();
                    check_field("point_valid", want.pen, i_point_valid);
                    check_field("screen_x", want.sx, i_screen_x);
                    check_field("screen_y", want.sy, i_screen_y);
                end
            end
        end
        o_pending        <= expected_points.size();
        o_mismatches     <= mismatch_count;
        o_points_checked <= checked_count;
    end

endmodule

[dv/touch_point_median_calibrate_core_tb.sv]
`timescale 1ns / 1ps

module touch_point_median_calibrate_core_tb;
    import tpmc_pkg::*;

    localparam int IDLE_PCT     = 32;
    localparam int PEN_PCT      = 85;
    localparam int QUIET_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 20;

    // Indexes past the register list; writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_wdata;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic                 i_pen_down;
    logic [WORD_W-1:0]    i_xchan_word_a, i_xchan_word_b, i_xchan_word_c;
    logic [WORD_W-1:0]    i_ychan_word_a, i_ychan_word_b, i_ychan_word_c;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic                 o_point_valid;
    logic [CFG_W-1:0]     o_screen_x, o_screen_y;

    int mismatches, points_pending, points_checked;
    int events_sent = 0;
    int settings_used = 1;
    int quiet_cycles = 0;

    // Held high for a stretch with no idling on either side
    logic steady;

    // Current calibration, kept only to aim the random samples at the windows
    logic [CFG_W-1:0] cur_x_lo, cur_x_hi, cur_y_lo, cur_y_hi;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    touch_point_median_calibrate_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_pen_down     (i_pen_down),
        .i_xchan_word_a (i_xchan_word_a),
        .i_xchan_word_b (i_xchan_word_b),
        .i_xchan_word_c (i_xchan_word_c),
        .i_ychan_word_a (i_ychan_word_a),
        .i_ychan_word_b (i_ychan_word_b),
        .i_ychan_word_c (i_ychan_word_c),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_point_valid  (o_point_valid),
        .o_screen_x     (o_screen_x),
        .o_screen_y     (o_screen_y)
    );

    touch_point_checker checker_i (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_pen_down       (i_pen_down),
        .i_xchan_word_a   (i_xchan_word_a),
        .i_xchan_word_b   (i_xchan_word_b),
        .i_xchan_word_c   (i_xchan_word_c),
        .i_ychan_word_a   (i_ychan_word_a),
        .i_ychan_word_b   (i_ychan_word_b),
        .i_ychan_word_c   (i_ychan_word_c),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_point_valid    (o_point_valid),
        .i_screen_x       (o_screen_x),
        .i_screen_y       (o_screen_y),
        .o_mismatches     (mismatches),
        .o_pending        (points_pending),
        .o_points_checked (points_checked)
    );

    // Receiver back-pressure: stall at random unless in the steady stretch
    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_out_stall <= 1'b0;
        else
            i_out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // Watchdog: end the run once nothing has moved on either channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
            $display("touch_point_median_calibrate_core test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // One converter word: the 12-bit sample sits on top, the low nibble is noise.
    // Mostly aim inside the window (with a margin either side), sometimes at its
    // edges or the range limits, sometimes anywhere at all.
    function automatic logic [WORD_W-1:0] raw_word(input logic [CFG_W-1:0] lo, hi);
        logic [31:0]      noise;
        logic [CFG_W-1:0] s;
        int unsigned      pick, a, b;
        noise = $urandom;
        pick  = $urandom_range(0, 99);
        a = (lo < hi) ? lo : hi;
        b = (lo < hi) ? hi : lo;
        if (pick < 25) begin
            return noise[WORD_W-1:0];
        end else if (pick < 40) begin
            case ($urandom_range(0, 5))
                0:       s = '0;
                1:       s = '1;
                2:       s = lo;
                3:       s = hi;
                4:       s = lo - 1'b1;
                default: s = hi + 1'b1;
            endcase
        end else begin
            a = (a > 20) ? a - 20 : 0;
            b = (b + 20 > 4095) ? 4095 : b + 20;
            s = CFG_W'($urandom_range(a, b));
        end
        return {s, noise[19:16]};
    endfunction

    // Offer one touch event and hold it until taken; leave valid high afterwards
    task automatic drive_event(input logic pen,
                               input logic [WORD_W-1:0] xa, xb, xc, ya, yb, yc);
        while (!steady && ($urandom_range(0, 99) < IDLE_PCT)) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_pen_down     <= pen;
        i_xchan_word_a <= xa;
        i_xchan_word_b <= xb;
        i_xchan_word_c <= xc;
        i_ychan_word_a <= ya;
        i_ychan_word_b <= yb;
        i_ychan_word_c <= yc;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        events_sent++;
    endtask

    // X channel samples fall in the screen-y window, Y channel in the screen-x one
    task automatic random_events(input int count);
        logic pen;
        for (int n = 0; n < count; n++) begin
            pen = ($urandom_range(0, 99) < PEN_PCT);
            drive_event(pen,
                        raw_word(cur_y_lo, cur_y_hi), raw_word(cur_y_lo, cur_y_hi),
                        raw_word(cur_y_lo, cur_y_hi),
                        raw_word(cur_x_lo, cur_x_hi), raw_word(cur_x_lo, cur_x_hi),
                        raw_word(cur_x_lo, cur_x_hi));
        end
    endtask

    // Hold the sender until every outstanding point has come out
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (points_pending != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
    endtask

    // Write all six registers back to back; only call with the block drained
    task automatic set_calibration(input logic [CFG_W-1:0] xlo, xhi, ylo, yhi, xtop, ytop);
        write_reg(REG_X_RAW_MIN, xlo);
        write_reg(REG_X_RAW_MAX, xhi);
        write_reg(REG_Y_RAW_MIN, ylo);
        write_reg(REG_Y_RAW_MAX, yhi);
        write_reg(REG_X_OUT_MAX, xtop);
        write_reg(REG_Y_OUT_MAX, ytop);
        i_cfg_we <= 1'b0;
        cur_x_lo = xlo;
        cur_x_hi = xhi;
        cur_y_lo = ylo;
        cur_y_hi = yhi;
        settings_used++;
    endtask

    initial begin : stimulus
        int unsigned xlo, ylo;

        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = REG_X_RAW_MIN;
        i_cfg_wdata    = '0;
        i_in_valid     = 1'b0;
        i_pen_down     = 1'b0;
        i_xchan_word_a = '0;
        i_xchan_word_b = '0;
        i_xchan_word_c = '0;
        i_ychan_word_a = '0;
        i_ychan_word_b = '0;
        i_ychan_word_c = '0;
        steady         = 1'b0;
        cur_x_lo       = RST_X_RAW_MIN;
        cur_x_hi       = RST_X_RAW_MAX;
        cur_y_lo       = RST_Y_RAW_MIN;
        cur_y_hi       = RST_Y_RAW_MAX;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed events on the reset calibration.
        // Pen up: coordinates must read zero whatever the words hold.
        drive_event(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        drive_event(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        drive_event(1'b0, 16'h1234, 16'hABCD, 16'h5A5A, 16'hA5A5, 16'h0F0F, 16'hF0F0);
        // Range limits: clamp below the window and above it
        drive_event(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        drive_event(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        // Exactly on the window edges, one step outside them and one step inside
        drive_event(1'b1, 16'h0960, 16'h0960, 16'h0960, 16'h0960, 16'h0960, 16'h0960);
        drive_event(1'b1, 16'hDAC0, 16'hDAC0, 16'hDAC0, 16'hDDE0, 16'hDDE0, 16'hDDE0);
        drive_event(1'b1, 16'h0950, 16'h0950, 16'h0950, 16'h095F, 16'h095F, 16'h095F);
        drive_event(1'b1, 16'hDAD0, 16'hDADF, 16'hDAD7, 16'hDDF0, 16'hDDF3, 16'hDDFF);
        drive_event(1'b1, 16'h0970, 16'h0970, 16'h0970, 16'hDDD0, 16'hDDD0, 16'hDDD0);
        // Median taken from each position in turn
        drive_event(1'b1, 16'h4000, 16'h1000, 16'h8000, 16'h8005, 16'h400F, 16'h100A);
        drive_event(1'b1, 16'h1000, 16'h8000, 16'h4000, 16'h1000, 16'h4000, 16'h8000);
        drive_event(1'b1, 16'h8000, 16'h4000, 16'h1000, 16'h4000, 16'h8000, 16'h1000);
        // Two equal samples, equal samples differing only in the low nibble, and a spread over the full range
        drive_event(1'b1, 16'h2000, 16'h2000, 16'h7000, 16'h9000, 16'h3000, 16'h9000);
        drive_event(1'b1, 16'h555F, 16'h5550, 16'h555A, 16'hAAA0, 16'hAAAF, 16'hAAA5);
        drive_event(1'b1, 16'h000F, 16'hFFF0, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000);
        random_events(200);

        // Full range, widest screen; writes past the list must be dropped.
        // Run this setting with no idling at all.
        drain_results();
        write_reg(REG_SPARE_LO, CFG_W'($urandom_range(0, 4095)));
        write_reg(REG_SPARE_HI, CFG_W'($urandom_range(0, 4095)));
        set_calibration(12'd0, 12'd4095, 12'd0, 12'd4095, 12'd4095, 12'd4095);
        steady <= 1'b1;
        random_events(200);
        steady <= 1'b0;

        // Empty windows: max equal to min on one axis, below it on the other
        drain_results();
        set_calibration(12'd2000, 12'd2000, 12'd3000, 12'd1000, 12'd4095, 12'd100);
        random_events(150);

        // One-step windows at both ends of the range, zero-sized screen
        drain_results();
        set_calibration(12'd4094, 12'd4095, 12'd0, 12'd1, 12'd0, 12'd0);
        random_events(150);

        // Random windows in order
        drain_results();
        xlo = $urandom_range(0, 4000);
        ylo = $urandom_range(0, 4000);
        set_calibration(CFG_W'(xlo), CFG_W'($urandom_range(xlo + 1, 4095)),
                        CFG_W'(ylo), CFG_W'($urandom_range(ylo + 1, 4095)),
                        CFG_W'($urandom_range(1, 4095)), CFG_W'($urandom_range(1, 4095)));
        random_events(250);

        // Back to the reset calibration, written explicitly
        drain_results();
        set_calibration(RST_X_RAW_MIN, RST_X_RAW_MAX, RST_Y_RAW_MIN, RST_Y_RAW_MAX,
                        RST_X_OUT_MAX, RST_Y_OUT_MAX);
        random_events(200);

        // Anything goes, inverted windows included
        drain_results();
        set_calibration(CFG_W'($urandom_range(0, 4095)), CFG_W'($urandom_range(0, 4095)),
                        CFG_W'($urandom_range(0, 4095)), CFG_W'($urandom_range(0, 4095)),
                        CFG_W'($urandom_range(0, 4095)), CFG_W'($urandom_range(0, 4095)));
        random_events(250);

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d touch events across %0d calibration settings; %0d points compared",
                 events_sent, settings_used, points_checked);
        $display("Covered pen up, clamping, empty windows, edge windows and spare indexes");
        if (mismatches == 0)
            $display("touch_point_median_calibrate_core test passed");
        else
            $display("touch_point_median_calibrate_core test failed");
        $finish;
    end

endmodule
